// ===== rtl/gasp_pkg.sv =====
`default_nettype none
package gasp_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int MAX_PAGES     = 16;
	localparam int PAGES_W       = $clog2(MAX_PAGES + 1);

	localparam int SIZE_W     = 13;
	localparam int CP_W       = 21;
	localparam int DIM_W      = 10;
	localparam int POS_W      = 12;
	localparam int PAGE_W     = 4;
	localparam int STATUS_W   = 3;
	localparam int PAD        = 1;
	localparam int SIZE_MIN   = 16;
	localparam int SIZE_MAX   = 4096;
	localparam int SIZE_RESET = 1024;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 56;

	typedef enum logic [STATUS_W-1:0] {
		ST_HIT     = 3'd0,
		ST_PLACED  = 3'd1,
		ST_NODRAW  = 3'd2,
		ST_FULL    = 3'd3,
		ST_LIMIT   = 3'd4,
		ST_CLEARED = 3'd5
	} status_t;

	typedef struct packed {
		logic [DIM_W-1:0]  height;
		logic [DIM_W-1:0]  width;
		logic [POS_W-1:0]  y;
		logic [POS_W-1:0]  x;
		logic [PAGE_W-1:0] page;
		logic              drawable;
	} place_t;

	localparam int PLACE_W = $bits(place_t);

	typedef struct packed {
		logic clear;
		logic commit;
	} shelf_ctl_t;

	typedef struct packed {
		logic              limit;
		logic [PAGE_W-1:0] page;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
	} shelf_res_t;

	function automatic logic [IDX_W-1:0] key_hash(input logic [CP_W-1:0] cp);
		logic [IDX_W-1:0] h;
		h = '0;
		for (int i = 0; i < CP_W; i++) begin
			h[i % IDX_W] = h[i % IDX_W] ^ cp[i];
		end
		return h;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/gasp_ram.sv =====
`default_nettype none
module gasp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/gasp_shelf.sv =====
`default_nettype none
module gasp_shelf import gasp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  shelf_ctl_t         ctl,
	input  logic [SIZE_W-1:0]  size,
	input  logic [DIM_W-1:0]   glyph_width,
	input  logic [DIM_W-1:0]   glyph_height,
	output shelf_res_t         res
);

	logic [SIZE_W-1:0]  cur_x_q;
	logic [SIZE_W-1:0]  cur_y_q;
	logic [DIM_W-1:0]   row_h_q;
	logic [PAGES_W-1:0] pages_q;

	logic [SIZE_W:0]    end_x;
	logic               wrap;
	logic [SIZE_W:0]    wx;
	logic [SIZE_W:0]    wy;
	logic [DIM_W-1:0]   wrh;
	logic [SIZE_W:0]    end_y;
	logic               fits;
	logic [PAGES_W-1:0] new_pages;
	logic [SIZE_W:0]    px;
	logic [SIZE_W:0]    py;
	logic [DIM_W-1:0]   prh;
	logic [SIZE_W:0]    next_x;

	always_comb begin
		end_x = (SIZE_W+1)'(cur_x_q) + (SIZE_W+1)'(glyph_width) + (SIZE_W+1)'(PAD);
		wrap  = end_x > (SIZE_W+1)'(size);
		wx    = wrap ? (SIZE_W+1)'(PAD) : (SIZE_W+1)'(cur_x_q);
		wy    = wrap ? (SIZE_W+1)'(cur_y_q) + (SIZE_W+1)'(row_h_q) + (SIZE_W+1)'(PAD)
			: (SIZE_W+1)'(cur_y_q);
		wrh   = wrap ? '0 : row_h_q;
		end_y = wy + (SIZE_W+1)'(glyph_height) + (SIZE_W+1)'(PAD);
		fits  = (pages_q != '0) && (end_y <= (SIZE_W+1)'(size));

		new_pages = fits ? pages_q : pages_q + PAGES_W'(1);
		px        = fits ? wx : (SIZE_W+1)'(PAD);
		py        = fits ? wy : (SIZE_W+1)'(PAD);
		prh       = fits ? wrh : '0;
		next_x    = px + (SIZE_W+1)'(glyph_width) + (SIZE_W+1)'(PAD);

		res.limit = !fits && (pages_q >= PAGES_W'(MAX_PAGES));
		res.page  = PAGE_W'(new_pages - PAGES_W'(1));
		res.x     = px[POS_W-1:0];
		res.y     = py[POS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= SIZE_W'(PAD);
			cur_y_q <= SIZE_W'(PAD);
			row_h_q <= '0;
			pages_q <= '0;
		end else if (ctl.clear) begin
			cur_x_q <= SIZE_W'(PAD);
			cur_y_q <= SIZE_W'(PAD);
			row_h_q <= '0;
			pages_q <= '0;
		end else if (ctl.commit) begin
			cur_x_q <= next_x[SIZE_W-1:0];
			cur_y_q <= py[SIZE_W-1:0];
			row_h_q <= (glyph_height > prh) ? glyph_height : prh;
			pages_q <= new_pages;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/glyph_atlas_shelf_placer.sv =====
// Channel   Direction  Signals                               Payload
// config    in         cfg_we, cfg_wdata                     page_size
// request   in         s_tvalid, s_tready, s_tdata, s_tuser  mode, codepoint, width, height
// result    out        m_tvalid, m_tready, m_tdata, m_tuser  status, placement
//
// One item at a time. A clear goes straight to the output state; a placement, a non-drawable
// record or a page limit is decided in the compare state; a hit is read in the hit state.
// Probing passes each occupied table slot in turn (one read of the synchronous key memory
// per probe; a full table probes all TABLE_ENTRIES slots). The input is ready again once
// the result is registered. Reset and clear empty the table at once through per-slot valid
// flip-flops. A stalled result holds the next item in the output state until it is taken.
`default_nettype none
module glyph_atlas_shelf_placer import gasp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [SIZE_W-1:0]      cfg_wdata,   // page_size
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,     // codepoint, glyph_width, glyph_height
	input  logic                   s_tuser,     // mode
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,     // drawable, page_index, place_x, place_y,
	                                            // out_width, out_height
	output logic [STATUS_W-1:0]    m_tuser      // status
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CMP  = 4'b0010,
		S_HIT  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t                   state_q;
	logic [SIZE_W-1:0]        page_size_q;
	logic [CP_W-1:0]          cp_q;
	logic [DIM_W-1:0]         w_q;
	logic [DIM_W-1:0]         h_q;
	logic [IDX_W-1:0]         idx_q;
	logic [IDX_W-1:0]         probe_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic                     vld_rd_q;
	place_t                   res_place_q;
	status_t                  res_status_q;
	logic                     m_tvalid_q;
	logic [OUT_TDATA_W-1:0]   m_tdata_q;
	logic [STATUS_W-1:0]      m_tuser_q;

	logic [SIZE_W-1:0]  size_eff;
	logic               accept;
	logic [CP_W-1:0]    s_cp;
	logic [DIM_W-1:0]   s_w;
	logic [DIM_W-1:0]   s_h;
	logic [IDX_W-1:0]   key_raddr;
	logic [CP_W-1:0]    key_rdata;
	logic [PLACE_W-1:0] place_rdata;
	logic               hit;
	logic               empty;
	logic               nodraw;
	logic               store;
	place_t             new_place;
	shelf_ctl_t         shelf_ctl;
	shelf_res_t         shelf_res;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign s_cp     = s_tdata[CP_W-1:0];
	assign s_w      = s_tdata[CP_W +: DIM_W];
	assign s_h      = s_tdata[CP_W+DIM_W +: DIM_W];

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_comb begin
		if (page_size_q < SIZE_W'(SIZE_MIN)) begin
			size_eff = SIZE_W'(SIZE_MIN);
		end else if (page_size_q > SIZE_W'(SIZE_MAX)) begin
			size_eff = SIZE_W'(SIZE_MAX);
		end else begin
			size_eff = page_size_q;
		end
	end

	assign key_raddr = (state_q == S_IDLE) ? key_hash(s_cp) : idx_q + IDX_W'(1);

	always_comb begin
		hit    = vld_rd_q && (key_rdata == cp_q);
		empty  = !vld_rd_q;
		nodraw = (w_q == '0) || (h_q == '0)
			|| (SIZE_W'(w_q) + SIZE_W'(2 * PAD) > size_eff)
			|| (SIZE_W'(h_q) + SIZE_W'(2 * PAD) > size_eff);
		store  = (state_q == S_CMP) && empty && (nodraw || !shelf_res.limit);

		new_place.height   = h_q;
		new_place.width    = w_q;
		new_place.y        = nodraw ? '0 : shelf_res.y;
		new_place.x        = nodraw ? '0 : shelf_res.x;
		new_place.page     = nodraw ? '0 : shelf_res.page;
		new_place.drawable = !nodraw;

		shelf_ctl.clear  = accept && s_tuser;
		shelf_ctl.commit = store && !nodraw;
	end

	gasp_ram #(
		.WIDTH (CP_W),
		.DEPTH (TABLE_ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (store),
		.waddr (idx_q),
		.wdata (cp_q),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	gasp_ram #(
		.WIDTH (PLACE_W),
		.DEPTH (TABLE_ENTRIES)
	) u_place_ram (
		.clk   (clk),
		.we    (store),
		.waddr (idx_q),
		.wdata (new_place),
		.raddr (idx_q),
		.rdata (place_rdata)
	);

	gasp_shelf u_shelf (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (shelf_ctl),
		.size         (size_eff),
		.glyph_width  (w_q),
		.glyph_height (h_q),
		.res          (shelf_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q <= SIZE_W'(SIZE_RESET);
		end else if (cfg_we) begin
			page_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			vld_rd_q     <= 1'b0;
			cp_q         <= '0;
			w_q          <= '0;
			h_q          <= '0;
			idx_q        <= '0;
			probe_q      <= '0;
			res_place_q  <= '0;
			res_status_q <= ST_HIT;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= '0;
		end else begin
			vld_rd_q <= valid_q[key_raddr];
			if (m_tvalid_q && m_tready && (state_q != S_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			if (store) begin
				valid_q[idx_q] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (s_tuser) begin
							valid_q      <= '0;
							res_place_q  <= '0;
							res_status_q <= ST_CLEARED;
							state_q      <= S_OUT;
						end else begin
							cp_q    <= s_cp;
							w_q     <= s_w;
							h_q     <= s_h;
							idx_q   <= key_hash(s_cp);
							probe_q <= '0;
							state_q <= S_CMP;
						end
					end
				end
				S_CMP: begin
					if (hit) begin
						state_q <= S_HIT;
					end else if (empty) begin
						if (nodraw) begin
							res_status_q <= ST_NODRAW;
							res_place_q  <= new_place;
						end else if (shelf_res.limit) begin
							res_status_q <= ST_LIMIT;
							res_place_q  <= '0;
						end else begin
							res_status_q <= ST_PLACED;
							res_place_q  <= new_place;
						end
						state_q <= S_OUT;
					end else if (probe_q == IDX_W'(TABLE_ENTRIES - 1)) begin
						res_status_q <= ST_FULL;
						res_place_q  <= '0;
						state_q      <= S_OUT;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						probe_q <= probe_q + IDX_W'(1);
					end
				end
				S_HIT: begin
					res_place_q  <= place_t'(place_rdata);
					res_status_q <= ST_HIT;
					state_q      <= S_OUT;
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= OUT_TDATA_W'(res_place_q);
						m_tuser_q  <= res_status_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/gasp_checker.sv =====
`default_nettype none
module gasp_checker import gasp_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [STATUS_W-1:0]    m_tuser
);

	// one item in flight: no acceptance in the cycle after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while an item is in flight");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser <= STATUS_W'(ST_CLEARED)))
		else $error("status out of range");

	a_drawable_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tuser == ST_HIT || m_tuser == ST_PLACED))
		else $error("drawable result with wrong status");

	a_empty_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_LIMIT || m_tuser == ST_CLEARED))
		|-> (m_tdata == '0))
		else $error("payload not zero for full, limit or clear");

	a_nodraw_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[28:1] == '0))
		else $error("non-drawable result carries a position");

endmodule

bind glyph_atlas_shelf_placer gasp_checker u_gasp_checker (.*);
`default_nettype wire
